// ----- sv/bcr_pkg.sv -----
// Shared constants and types for the block-to-CHS request translator.
`timescale 1ns / 1ps

package bcr_pkg;

   // Sizing
   localparam int BLOCK_BITS = 32;
   localparam int CYL_BITS   = 16;
   localparam int BLK_IN_W   = 32;
   localparam int LOG_W      = 4;
   localparam int IDX_W      = BLOCK_BITS + (2 ** LOG_W) - 1;
   localparam int BLK_USE    = (BLOCK_BITS < BLK_IN_W) ? BLOCK_BITS : BLK_IN_W;
   localparam int SPC_W      = 16;
   localparam int SPT_W      = 8;
   localparam int HEAD_W     = 16;
   localparam int SECT_W     = 8;
   localparam int OUT_CYL_W  = 16;
   localparam int LEN_W      = 24;
   localparam int ADDR_W     = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Command codes
   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SECT_PER_CYL  = 2'd0,
      CSR_SECT_PER_TRK  = 2'd1,
      CSR_SECT_SIZE_LOG = 2'd2,
      CSR_SECT_BLK_LOG  = 2'd3
   } csr_index_type;

   // Fields that ride along with the division
   typedef struct packed {
      logic [LEN_W-1:0]  sector_count;
      logic [ADDR_W-1:0] transfer_address;
      logic              command;
   } side_type;

   // Everything known once the cylinder division is done
   typedef struct packed {
      side_type              side;
      logic [CYL_BITS-1:0]   cylinder;
      logic                  overflow;
   } cyl_tag_type;

endpackage

// ----- sv/bcr_cyl_div.sv -----
// Pipelined restoring divider: sector index / sectors per cylinder, one bit per stage.
`timescale 1ns / 1ps

module bcr_cyl_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic                       in_valid,
   input  logic [bcr_pkg::IDX_W-1:0]  in_dividend,
   input  logic [bcr_pkg::SPC_W-1:0]  in_divisor,
   input  bcr_pkg::side_type          in_side,
   output logic                       out_valid,
   output logic [bcr_pkg::CYL_BITS-1:0] out_quot,
   output logic                       out_ovf,
   output logic [bcr_pkg::SPC_W-1:0]  out_rem,
   output bcr_pkg::side_type          out_side
);
   import bcr_pkg::*;

   localparam int STAGES = IDX_W;

   // Values entering each stage; entry STAGES is the last register
   logic                 valid_cur [0:STAGES];
   logic [IDX_W-1:0]     dvd_cur   [0:STAGES];
   logic [SPC_W-1:0]     rem_cur   [0:STAGES];
   logic [CYL_BITS-1:0]  quot_cur  [0:STAGES];
   logic                 ovf_cur   [0:STAGES];
   side_type             side_cur  [0:STAGES];

   logic                 valid_ff  [0:STAGES-1];
   logic [IDX_W-1:0]     dvd_ff    [0:STAGES-1];
   logic [SPC_W-1:0]     rem_ff    [0:STAGES-1];
   logic [CYL_BITS-1:0]  quot_ff   [0:STAGES-1];
   logic                 ovf_ff    [0:STAGES-1];
   side_type             side_ff   [0:STAGES-1];

   logic [IDX_W-1:0]     dvd_in    [0:STAGES-1];
   logic [SPC_W-1:0]     rem_in    [0:STAGES-1];
   logic [CYL_BITS-1:0]  quot_in   [0:STAGES-1];
   logic                 ovf_in    [0:STAGES-1];

   assign valid_cur[0] = in_valid;
   assign dvd_cur[0]   = in_dividend;
   assign rem_cur[0]   = '0;
   assign quot_cur[0]  = '0;
   assign ovf_cur[0]   = 1'b0;
   assign side_cur[0]  = in_side;

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      logic [SPC_W:0] trial;
      logic           fits;

      // One quotient bit: shift in the next dividend bit and try the subtract
      assign trial      = {rem_cur[k], dvd_cur[k][IDX_W-1]};
      assign fits       = (trial >= {1'b0, in_divisor});
      assign rem_in[k]  = fits ? SPC_W'(trial - {1'b0, in_divisor}) : trial[SPC_W-1:0];
      assign dvd_in[k]  = {dvd_cur[k][IDX_W-2:0], 1'b0};
      assign quot_in[k] = {quot_cur[k][CYL_BITS-2:0], fits};
      // Bits pushed out above the cylinder width mark an overflow
      assign ovf_in[k]  = ovf_cur[k] | quot_cur[k][CYL_BITS-1];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= valid_cur[k];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            dvd_ff[k]  <= dvd_in[k];
            rem_ff[k]  <= rem_in[k];
            quot_ff[k] <= quot_in[k];
            ovf_ff[k]  <= ovf_in[k];
            side_ff[k] <= side_cur[k];
         end
      end

      assign valid_cur[k+1] = valid_ff[k];
      assign dvd_cur[k+1]   = dvd_ff[k];
      assign rem_cur[k+1]   = rem_ff[k];
      assign quot_cur[k+1]  = quot_ff[k];
      assign ovf_cur[k+1]   = ovf_ff[k];
      assign side_cur[k+1]  = side_ff[k];
   end

   assign out_valid = valid_cur[STAGES];
   assign out_quot  = quot_cur[STAGES];
   assign out_ovf   = ovf_cur[STAGES];
   assign out_rem   = rem_cur[STAGES];
   assign out_side  = side_cur[STAGES];

`ifndef SYNTHESIS
   // A finished remainder is always below the divisor
   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (out_rem < in_divisor))
      else $error("cylinder remainder not below sectors per cylinder");
`endif

endmodule

// ----- sv/bcr_head_div.sv -----
// Pipelined restoring divider: cylinder remainder / sectors per track gives head and sector.
`timescale 1ns / 1ps

module bcr_head_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        in_valid,
   input  logic [bcr_pkg::HEAD_W-1:0]  in_dividend,
   input  logic [bcr_pkg::SPT_W-1:0]   in_divisor,
   input  bcr_pkg::cyl_tag_type        in_tag,
   output logic                        out_valid,
   output logic [bcr_pkg::HEAD_W-1:0]  out_head,
   output logic [bcr_pkg::SECT_W-1:0]  out_sector,
   output bcr_pkg::cyl_tag_type        out_tag
);
   import bcr_pkg::*;

   localparam int STAGES = HEAD_W;

   logic                valid_cur [0:STAGES];
   logic [HEAD_W-1:0]   dvd_cur   [0:STAGES];
   logic [SPT_W-1:0]    rem_cur   [0:STAGES];
   logic [HEAD_W-1:0]   quot_cur  [0:STAGES];
   cyl_tag_type         tag_cur   [0:STAGES];

   logic                valid_ff  [0:STAGES-1];
   logic [HEAD_W-1:0]   dvd_ff    [0:STAGES-1];
   logic [SPT_W-1:0]    rem_ff    [0:STAGES-1];
   logic [HEAD_W-1:0]   quot_ff   [0:STAGES-1];
   cyl_tag_type         tag_ff    [0:STAGES-1];

   logic [HEAD_W-1:0]   dvd_in    [0:STAGES-1];
   logic [SPT_W-1:0]    rem_in    [0:STAGES-1];
   logic [HEAD_W-1:0]   quot_in   [0:STAGES-1];

   assign valid_cur[0] = in_valid;
   assign dvd_cur[0]   = in_dividend;
   assign rem_cur[0]   = '0;
   assign quot_cur[0]  = '0;
   assign tag_cur[0]   = in_tag;

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      logic [SPT_W:0] trial;
      logic           fits;

      // One head bit per stage
      assign trial      = {rem_cur[k], dvd_cur[k][HEAD_W-1]};
      assign fits       = (trial >= {1'b0, in_divisor});
      assign rem_in[k]  = fits ? SPT_W'(trial - {1'b0, in_divisor}) : trial[SPT_W-1:0];
      assign dvd_in[k]  = {dvd_cur[k][HEAD_W-2:0], 1'b0};
      assign quot_in[k] = {quot_cur[k][HEAD_W-2:0], fits};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= valid_cur[k];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            dvd_ff[k]  <= dvd_in[k];
            rem_ff[k]  <= rem_in[k];
            quot_ff[k] <= quot_in[k];
            tag_ff[k]  <= tag_cur[k];
         end
      end

      assign valid_cur[k+1] = valid_ff[k];
      assign dvd_cur[k+1]   = dvd_ff[k];
      assign rem_cur[k+1]   = rem_ff[k];
      assign quot_cur[k+1]  = quot_ff[k];
      assign tag_cur[k+1]   = tag_ff[k];
   end

   assign out_valid  = valid_cur[STAGES];
   assign out_head   = quot_cur[STAGES];
   assign out_sector = SECT_W'(rem_cur[STAGES]);
   assign out_tag    = tag_cur[STAGES];

`ifndef SYNTHESIS
   // Sector must land inside the track
   a_sector_in_track: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (rem_cur[STAGES] < in_divisor))
      else $error("sector not below sectors per track");
`endif

endmodule

// ----- sv/block_to_chs_request.sv -----
// Top level: translates a block transfer request into cylinder, head and sector.
//
//   port group  direction  handshake           carries
//   req_*       in         req_valid/req_stall block number, length, buffer address, read mark
//   rsp_*       out        rsp_valid/rsp_stall cylinder, head, sector, count, address, command
//   csr_*       in         csr_valid/csr_ready register index and write data
//
// There is one register stage per quotient bit of the cylinder divider, then one
// register stage per head bit of the head divider.
// One request is accepted per cycle unless req_stall is high; the divider pipelines allow it.
// The whole pipeline holds while a result waits on rsp_stall; req_stall follows it.
// Reset is synchronous and clears the valid bits and loads the default geometry.
// The register port is always ready; writes take effect on the next cycle.
`timescale 1ns / 1ps

module block_to_chs_request (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [bcr_pkg::BLK_IN_W-1:0]    req_block_number,
   input  logic [bcr_pkg::LEN_W-1:0]       req_length_bytes,
   input  logic [bcr_pkg::ADDR_W-1:0]      req_buffer_address,
   input  logic                            req_is_read,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [bcr_pkg::OUT_CYL_W-1:0]   rsp_cylinder,
   output logic [bcr_pkg::HEAD_W-1:0]      rsp_head,
   output logic [bcr_pkg::SECT_W-1:0]      rsp_sector,
   output logic [bcr_pkg::LEN_W-1:0]       rsp_sector_count,
   output logic [bcr_pkg::ADDR_W-1:0]      rsp_transfer_address,
   output logic                            rsp_command,
   output logic                            rsp_cylinder_overflow,
   // register write channel
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bcr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bcr_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import bcr_pkg::*;

   logic [SPC_W-1:0]  spc_ff;
   logic [SPT_W-1:0]  spt_ff;
   logic [LOG_W-1:0]  ssl_ff;
   logic [LOG_W-1:0]  sbl_ff;
   logic [SPC_W-1:0]  spc_eff;
   logic [SPT_W-1:0]  spt_eff;

   logic              advance;
   logic [IDX_W-1:0]  sector_index;
   side_type          req_side;

   logic              cyl_valid;
   logic [CYL_BITS-1:0] cyl_quot;
   logic              cyl_ovf;
   logic [SPC_W-1:0]  cyl_rem;
   side_type          cyl_side;
   cyl_tag_type       cyl_tag;

   logic              out_valid;
   logic [HEAD_W-1:0] out_head;
   logic [SECT_W-1:0] out_sector;
   cyl_tag_type       out_tag;

   // Geometry registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         spc_ff <= SPC_W'(1);
         spt_ff <= SPT_W'(1);
         ssl_ff <= LOG_W'(9);
         sbl_ff <= LOG_W'(1);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SECT_PER_CYL:  spc_ff <= csr_wdata[SPC_W-1:0];
            CSR_SECT_PER_TRK:  spt_ff <= csr_wdata[SPT_W-1:0];
            CSR_SECT_SIZE_LOG: ssl_ff <= csr_wdata[LOG_W-1:0];
            CSR_SECT_BLK_LOG:  sbl_ff <= csr_wdata[LOG_W-1:0];
            default: ;
         endcase
      end
   end

   // Zero geometry divides by one
   assign spc_eff = (spc_ff == '0) ? SPC_W'(1) : spc_ff;
   assign spt_eff = (spt_ff == '0) ? SPT_W'(1) : spt_ff;

   // Whole pipeline moves unless the finished result is held
   assign advance   = !(out_valid && rsp_stall);
   assign req_stall = !advance;

   // Entry: block to sector index, length to sector count
   assign sector_index              = IDX_W'(req_block_number[BLK_USE-1:0]) << sbl_ff;
   assign req_side.sector_count     = req_length_bytes >> ssl_ff;
   assign req_side.transfer_address = req_buffer_address;
   assign req_side.command          = req_is_read ? CMD_READ : CMD_WRITE;

   bcr_cyl_div u_cyl_div (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (req_valid),
      .in_dividend (sector_index),
      .in_divisor  (spc_eff),
      .in_side     (req_side),
      .out_valid   (cyl_valid),
      .out_quot    (cyl_quot),
      .out_ovf     (cyl_ovf),
      .out_rem     (cyl_rem),
      .out_side    (cyl_side)
   );

   assign cyl_tag.side     = cyl_side;
   assign cyl_tag.cylinder = cyl_quot;
   assign cyl_tag.overflow = cyl_ovf;

   bcr_head_div u_head_div (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (cyl_valid),
      .in_dividend (cyl_rem),
      .in_divisor  (spt_eff),
      .in_tag      (cyl_tag),
      .out_valid   (out_valid),
      .out_head    (out_head),
      .out_sector  (out_sector),
      .out_tag     (out_tag)
   );

   // Result channel straight from the last stage register
   assign rsp_valid             = out_valid;
   assign rsp_cylinder          = OUT_CYL_W'(out_tag.cylinder);
   assign rsp_head              = out_head;
   assign rsp_sector            = out_sector;
   assign rsp_sector_count      = out_tag.side.sector_count;
   assign rsp_transfer_address  = out_tag.side.transfer_address;
   assign rsp_command           = out_tag.side.command;
   assign rsp_cylinder_overflow = out_tag.overflow;

`ifndef SYNTHESIS
   // Head and sector rebuild a remainder that fits within one cylinder
   a_head_sector_in_cyl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((32'(rsp_head) * 32'(spt_eff) + 32'(rsp_sector)) < 32'(spc_eff)))
      else $error("head and sector exceed one cylinder");
`endif

endmodule
